// File: rtl/core/mf2d_pkg.sv
package mf2d_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int IDX_W = 2;
	localparam int HALF_W = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_HALF_WIDTH   = 2'd2,
		REG_HALF_HEIGHT  = 2'd3
	} mf2d_reg_t;

	// Per-item control carried down the pipeline next to the pixel data.
	typedef struct packed {
		logic valid;
		logic emit;
		logic eof;
	} mf2d_tag_t;

endpackage

// File: rtl/core/mf2d_ram.sv
module mf2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/mf2d_line_window.sv
module mf2d_line_window #(
	parameter int MAX_WINDOW = 7,
	parameter int MAX_LINE = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         acc,
	input  logic [mf2d_pkg::PIX_W-1:0]   pix,
	input  logic [$clog2(MAX_LINE)-1:0]  col,
	output logic [mf2d_pkg::PIX_W-1:0]   win [MAX_WINDOW*MAX_WINDOW]
);
	import mf2d_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam int LANES = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
	localparam int WW = LANES * PIX_W;

	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    col_s1;
	logic             v_s1;
	logic [WW-1:0]    rd_data;
	logic [WW-1:0]    word;
	logic [WW-1:0]    new_word;
	logic [CW-1:0]    wr_col_q;
	logic [WW-1:0]    wr_data_q;
	logic             wr_v_q;
	logic             wr_en;
	logic [PIX_W-1:0] win_q [MAX_WINDOW*MAX_WINDOW];

	// Each word holds one column of the last rows, newest row in the low lane.
	mf2d_ram #(.WIDTH(WW), .DEPTH(MAX_LINE)) u_line_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s1),
		.wdata(new_word),
		.re   (acc),
		.raddr(col),
		.rdata(rd_data)
	);

	assign wr_en = en && v_s1;

	// The read issued on the edge of the previous write misses that write.
	assign word = (wr_v_q && wr_col_q == col_s1) ? wr_data_q : rd_data;

	generate
		if (LANES > 1) begin : g_shift
			assign new_word = {word[WW-PIX_W-1:0], pix_s1};
		end else begin : g_one
			assign new_word = pix_s1;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			wr_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			if (v_s1) begin
				wr_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pix;
			col_s1 <= col;
			if (v_s1) begin
				wr_col_q <= col_s1;
				wr_data_q <= new_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int y = 0; y < MAX_WINDOW; y++) begin
				for (int x = 0; x < MAX_WINDOW - 1; x++) begin
					win_q[y*MAX_WINDOW+x] <= win_q[y*MAX_WINDOW+x+1];
				end
			end
			win_q[MAX_WINDOW*MAX_WINDOW-1] <= pix_s1;
			for (int k = 1; k < MAX_WINDOW; k++) begin
				win_q[(MAX_WINDOW-1-k)*MAX_WINDOW+MAX_WINDOW-1] <= word[(k-1)*PIX_W +: PIX_W];
			end
		end
	end

	assign win = win_q;

endmodule

// File: rtl/core/mf2d_select.sv
module mf2d_select #(
	parameter int MAX_WINDOW = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  mf2d_pkg::mf2d_tag_t             tag,
	input  logic [mf2d_pkg::PIX_W-1:0]      win [MAX_WINDOW*MAX_WINDOW],
	input  logic [mf2d_pkg::HALF_W-1:0]     hw,
	input  logic [mf2d_pkg::HALF_W-1:0]     hh,
	output logic                            valid,
	output logic [mf2d_pkg::PIX_W-1:0]      median,
	output logic                            eof
);
	import mf2d_pkg::*;

	localparam int N = MAX_WINDOW * MAX_WINDOW;
	localparam int NB = $clog2(N + 1);

	logic [PIX_W-1:0] vals_q [PIX_W][N];
	logic [N-1:0]     mask_q [PIX_W];
	logic [NB-1:0]    k_q    [PIX_W];
	logic [PIX_W-1:0] res_q  [PIX_W];
	logic             v_q    [PIX_W];
	logic             eof_q  [PIX_W];

	logic [N-1:0]  mask0;
	logic [2:0]    ww;
	logic [2:0]    wh;
	logic [5:0]    cnt;
	logic [NB-1:0] k0;

	assign ww = {hw, 1'b1};
	assign wh = {hh, 1'b1};
	assign cnt = ww * wh;
	assign k0 = NB'(cnt >> 1);

	always_comb begin
		for (int y = 0; y < MAX_WINDOW; y++) begin
			for (int x = 0; x < MAX_WINDOW; x++) begin
				mask0[y*MAX_WINDOW+x] = (y >= MAX_WINDOW - int'(wh)) && (x >= MAX_WINDOW - int'(ww));
			end
		end
	end

	// One result bit per stage, most significant first: count candidates with a
	// zero in this bit and keep the half that holds the wanted rank.
	generate
		for (genvar s = 0; s < PIX_W; s++) begin : g_stage
			localparam int B = PIX_W - 1 - s;
			logic [PIX_W-1:0] vin [N];
			logic [N-1:0]     min;
			logic [NB-1:0]    kin;
			logic [PIX_W-1:0] rin;
			logic             vld;
			logic             ein;
			logic [N-1:0]     zeros;
			logic [N-1:0]     ones;
			logic [NB-1:0]    c0;

			if (s == 0) begin : g_first
				assign vin = win;
				assign min = mask0;
				assign kin = k0;
				assign rin = '0;
				assign vld = tag.valid && tag.emit;
				assign ein = tag.eof;
			end else begin : g_next
				assign vin = vals_q[s-1];
				assign min = mask_q[s-1];
				assign kin = k_q[s-1];
				assign rin = res_q[s-1];
				assign vld = v_q[s-1];
				assign ein = eof_q[s-1];
			end

			always_comb begin
				for (int i = 0; i < N; i++) begin
					zeros[i] = min[i] && !vin[i][B];
					ones[i] = min[i] && vin[i][B];
				end
			end
			assign c0 = NB'($countones(zeros));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[s] <= 1'b0;
				end else if (en) begin
					v_q[s] <= vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					vals_q[s] <= vin;
					eof_q[s] <= ein;
					if (kin < c0) begin
						mask_q[s] <= zeros;
						k_q[s] <= kin;
						res_q[s] <= rin;
					end else begin
						mask_q[s] <= ones;
						k_q[s] <= kin - c0;
						res_q[s] <= rin | (PIX_W'(1) << B);
					end
				end
			end
		end
	endgenerate

	assign valid = v_q[PIX_W-1];
	assign median = res_q[PIX_W-1];
	assign eof = eof_q[PIX_W-1];

endmodule

// File: rtl/core/median_filter_2d_window_core.sv
// Two-dimensional median filter for an 8-bit grayscale raster stream. The block
// takes one pixel per clock unless a stalled result holds the pipeline, and
// gives, for every pixel that completes a fully covered window, the median of
// the (2*half_width+1) x (2*half_height+1) pixels that end at it, so only the
// valid region of each frame comes out, in raster order, with end_of_frame set
// on the result of the frame's last pixel. A pixel passes through the line
// memory read, the window load and eight stages of the bit-by-bit rank search,
// and a new pixel can enter behind it before its result leaves. The line memory
// is a single one-port-write, one-port-read RAM of MAX_LINE words, each word
// holding one column of the last MAX_WINDOW-1 rows; it needs no clearing pass.
// The user must write registers only while the block is idle, as the block
// does not enforce it. Zero sizes act as one, oversized values saturate, and a
// frame that runs past its last pixel wraps to a new frame without frame_start.
module median_filter_2d_window_core #(
	parameter int MAX_WINDOW = 7,
	parameter int MAX_LINE = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mf2d_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mf2d_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mf2d_pkg::PIX_W-1:0]    pixel,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mf2d_pkg::PIX_W-1:0]    median,
	output logic                          end_of_frame
);
	import mf2d_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int MAX_HALF = (MAX_WINDOW - 1) / 2;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [HALF_W-1:0] hw_q;
	logic [HALF_W-1:0] hh_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;

	logic [CW:0]       ew;
	logic [RW:0]       eh;
	logic [HALF_W-1:0] hw;
	logic [HALF_W-1:0] hh;
	logic [2:0]        ww;
	logic [2:0]        wh;
	logic [CW:0]       cc;
	logic [RW:0]       rr;
	logic [CW:0]       cn;
	logic [RW:0]       rn;
	logic              en;
	logic              acc;
	mf2d_tag_t         tag_s0;
	mf2d_tag_t         tag_s1;
	mf2d_tag_t         tag_s2;
	logic [PIX_W-1:0]  win [MAX_WINDOW*MAX_WINDOW];

	// The whole pipeline moves together; it stops only while a result waits.
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign acc = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(640);
			height_q <= CFG_W'(480);
			hw_q <= HALF_W'(1);
			hh_q <= HALF_W'(1);
		end else if (cfg_we) begin
			unique case (mf2d_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_HALF_WIDTH:   hw_q <= cfg_data[HALF_W-1:0];
				REG_HALF_HEIGHT:  hh_q <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective sizes: zero acts as one, large values saturate.
	always_comb begin
		if (width_q == '0) begin
			ew = (CW+1)'(1);
		end else if (int'(width_q) > MAX_LINE) begin
			ew = (CW+1)'(MAX_LINE);
		end else begin
			ew = (CW+1)'(width_q);
		end
		if (height_q == '0) begin
			eh = (RW+1)'(1);
		end else if (int'(height_q) > MAX_ROWS) begin
			eh = (RW+1)'(MAX_ROWS);
		end else begin
			eh = (RW+1)'(height_q);
		end
		hw = (int'(hw_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : hw_q;
		hh = (int'(hh_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : hh_q;
	end

	assign ww = {hw, 1'b1};
	assign wh = {hh, 1'b1};

	// Position of the incoming pixel and the counters that follow it.
	always_comb begin
		cc = {1'b0, col_q};
		rr = {1'b0, row_q};
		if (frame_start) begin
			cc = '0;
			rr = '0;
		end
		if (cc >= ew) begin
			cc = '0;
			rr = rr + 1'b1;
		end
		if (rr >= eh) begin
			rr = '0;
		end
		cn = cc + 1'b1;
		rn = rr;
		if (cn >= ew) begin
			cn = '0;
			rn = rr + 1'b1;
			if (rn >= eh) begin
				rn = '0;
			end
		end
	end

	assign tag_s0.valid = 1'b1;
	assign tag_s0.emit = (int'(rr) + 1 >= int'(wh)) && (int'(cc) + 1 >= int'(ww));
	assign tag_s0.eof = (rr + 1'b1 == eh) && (cc + 1'b1 == ew);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			if (acc) begin
				col_q <= cn[CW-1:0];
				row_q <= rn[RW-1:0];
				tag_s1 <= tag_s0;
			end else begin
				tag_s1 <= '0;
			end
			tag_s2 <= tag_s1;
		end
	end

	mf2d_line_window #(.MAX_WINDOW(MAX_WINDOW), .MAX_LINE(MAX_LINE)) u_line_window (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.acc   (acc),
		.pix   (pixel),
		.col   (cc[CW-1:0]),
		.win   (win)
	);

	mf2d_select #(.MAX_WINDOW(MAX_WINDOW)) u_select (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.tag   (tag_s2),
		.win   (win),
		.hw    (hw),
		.hh    (hh),
		.valid (out_valid),
		.median(median),
		.eof   (end_of_frame)
	);

endmodule

// File: rtl/core/mf2d_checker.sv
module mf2d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] median,
	input logic       end_of_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(median) && $stable(end_of_frame))
		else $error("result changed while stalled");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

endmodule

bind median_filter_2d_window_core mf2d_checker u_mf2d_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.median      (median),
	.end_of_frame(end_of_frame)
);
